// File: hdl/icon_animation_sequencer_unit_assert.svh
// Assertion macros used by the icon sequencer checker.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ICON_ANIMATION_SEQUENCER_UNIT_ASSERT_SVH
`define ICON_ANIMATION_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("icon sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("icon sequencer check failed");

// Next-cycle implication that is checked through reset as well.
`define IAS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("icon sequencer check failed");

`endif

// File: hdl/ias_pkg.sv
// Shared types and constants of the icon animation sequencer.
// No dependencies; ias_word_mem, ias_step and the top level import this package.
`timescale 1ns / 1ps

package ias_pkg;

    // Sizing of the per-icon sequence store.
    localparam int NUM_ICONS = 64;
    localparam int SEQ_LEN   = 64;
    localparam int SLOT_W    = $clog2(NUM_ICONS);
    localparam int POS_W     = $clog2(SEQ_LEN);
    localparam int ADDR_W    = SLOT_W + POS_W;

    // Field widths of the beats.
    localparam int CMD_W  = 2;
    localparam int WORD_W = 16;
    localparam int CNT_W  = 8;
    localparam int PAL_W  = 3;
    localparam int BMP_W  = 3;
    localparam int FLIP_W = 2;

    // Special sequence words.
    localparam logic [WORD_W-1:0] STILL_CUR_WORD = 16'h0001;
    localparam logic [WORD_W-1:0] STILL_NXT_WORD = 16'h0100;
    localparam logic [WORD_W-1:0] EMPTY_WORD     = 16'h0000;

    // Command codes; the fourth code is unused and changes nothing.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    // Playback state of one icon slot, including the written flags of its words.
    typedef struct packed {
        logic [SEQ_LEN-1:0] written;
        logic [POS_W-1:0]   pos;
        logic [CNT_W-1:0]   count;
        logic [PAL_W-1:0]   palette;
        logic [BMP_W-1:0]   bitmap;
        logic [FLIP_W-1:0]  flip;
    } t_slot_state;

endpackage

// File: hdl/ias_word_mem.sv
// Sequence word store: one write port and two registered read ports.
// Depends on ias_pkg for the address and word widths.
`timescale 1ns / 1ps

module ias_word_mem (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [ias_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [ias_pkg::WORD_W-1:0]  i_wr_data,
    input  logic                        i_rd_en,
    input  logic [ias_pkg::ADDR_W-1:0]  i_rd_addr_a,
    input  logic [ias_pkg::ADDR_W-1:0]  i_rd_addr_b,
    output logic [ias_pkg::WORD_W-1:0]  o_rd_data_a,
    output logic [ias_pkg::WORD_W-1:0]  o_rd_data_b
);
    import ias_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [WORD_W-1:0] r_words [DEPTH];
    logic [WORD_W-1:0] r_rd_data_a;
    logic [WORD_W-1:0] r_rd_data_b;

    // Contents are undefined until written, so the array has no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_words[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data_a <= r_words[i_rd_addr_a];
            r_rd_data_b <= r_words[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

// File: hdl/ias_step.sv
// Next-state logic of one icon slot for a load, clear or tick command.
// Depends on ias_pkg for the slot state type and the command codes.
`timescale 1ns / 1ps

module ias_step (
    input  logic [ias_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ias_pkg::POS_W-1:0]   i_entry_index,
    input  ias_pkg::t_slot_state        i_state,
    input  logic [ias_pkg::WORD_W-1:0]  i_cur_word,
    input  logic [ias_pkg::WORD_W-1:0]  i_nxt_word,
    output ias_pkg::t_slot_state        o_state,
    output logic                        o_animated
);
    import ias_pkg::*;

    t_cmd             cmd;
    logic             still;
    logic [CNT_W:0]   count_inc;
    logic             advance;
    logic [POS_W:0]   pos_inc;
    logic             wrap;

    assign cmd = t_cmd'(i_cmd);

    // A word of delay one followed by a bare bitmap word marks a still icon.
    assign still = (i_cur_word == STILL_CUR_WORD) && (i_nxt_word == STILL_NXT_WORD);

    // The count is bumped first and then compared, so delays 0 and 1 both step each tick.
    assign count_inc = {1'b0, i_state.count} + (CNT_W + 1)'(1);
    assign advance   = count_inc >= {1'b0, i_cur_word[CNT_W-1:0]};

    // Stepping off the last word or onto an empty word returns to the start.
    assign pos_inc = {1'b0, i_state.pos} + (POS_W + 1)'(1);
    assign wrap    = (pos_inc >= (POS_W + 1)'(SEQ_LEN)) || (i_nxt_word == EMPTY_WORD);

    // Command decode.
    always_comb begin
        o_state    = i_state;
        o_animated = 1'b0;
        unique case (cmd)
            CMD_LOAD: begin
                o_state.written[i_entry_index] = 1'b1;
                o_state.pos                    = '0;
            end
            CMD_CLEAR: begin
                o_state.written = '0;
                o_state.pos     = '0;
            end
            CMD_TICK: begin
                if (still) begin
                    o_state.palette = '0;
                    o_state.bitmap  = '0;
                    o_state.flip    = '0;
                end else begin
                    o_animated      = 1'b1;
                    o_state.palette = i_cur_word[13:11];
                    o_state.bitmap  = i_cur_word[10:8];
                    o_state.flip    = i_cur_word[15:14];
                    if (advance) begin
                        o_state.count = '0;
                        o_state.pos   = wrap ? '0 : pos_inc[POS_W-1:0];
                    end else begin
                        o_state.count = count_inc[CNT_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hdl/icon_animation_sequencer_unit.sv
// Top level of the icon animation sequencer: slot state store, forwarding and pipeline.
// Depends on ias_pkg, ias_word_mem and ias_step.
`timescale 1ns / 1ps

// Usage
// Input channel: i_in_valid / o_in_stall carry one command beat (load a word, clear a
// slot, or tick a slot). Output channel: o_out_valid / i_out_stall carry one result beat
// per command, in command order, describing the addressed slot after the command.
// Each accepted beat is registered in the first stage, then the second stage, then the
// output register. Throughput: one beat per cycle while the receiver does not stall.
// Each beat passes a slot state read, a read of the current and next sequence words
// from the two ports of the word store, and one update step; results of a beat still
// in flight are forwarded to the next beat.
// Reset clears the pipeline and the per-slot valid flags, so every slot reads as
// stopped at position zero with no words. There is no clearing pass.
// When the receiver stalls, the finished result is held in the output register and
// the pipeline keeps filling; o_in_stall rises only once every stage is occupied.
module icon_animation_sequencer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ias_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ias_pkg::SLOT_W-1:0]  i_icon_slot,
    input  logic [ias_pkg::POS_W-1:0]   i_entry_index,
    input  logic [ias_pkg::WORD_W-1:0]  i_entry_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ias_pkg::PAL_W-1:0]   o_palette_line,
    output logic [ias_pkg::BMP_W-1:0]   o_bitmap_frame,
    output logic [ias_pkg::FLIP_W-1:0]  o_flip_mode,
    output logic [ias_pkg::POS_W-1:0]   o_frame_position,
    output logic                        o_is_animated
);
    import ias_pkg::*;

    // Slot state store with one valid flag per slot.
    t_slot_state        r_slot_mem [NUM_ICONS];
    logic [NUM_ICONS-1:0] r_row_valid;
    t_slot_state        r_state_rd;

    // First stage: command beat waiting for its slot state.
    logic               r_s1_valid;
    logic [CMD_W-1:0]   r_s1_cmd;
    logic [SLOT_W-1:0]  r_s1_slot;
    logic [POS_W-1:0]   r_s1_index;
    logic [WORD_W-1:0]  r_s1_word;

    // Second stage: slot state known, sequence words arriving from the store.
    logic               r_s2_valid;
    logic [CMD_W-1:0]   r_s2_cmd;
    logic [SLOT_W-1:0]  r_s2_slot;
    logic [POS_W-1:0]   r_s2_index;
    logic [WORD_W-1:0]  r_s2_word;
    t_slot_state        r_s2_state;
    logic               r_s2_cur_ok;
    logic               r_s2_nxt_ok;
    logic               r_s2_cur_byp;
    logic               r_s2_nxt_byp;
    logic [WORD_W-1:0]  r_s2_byp_word;

    // Last slot state written to the store.
    logic               r_wb_valid;
    logic [SLOT_W-1:0]  r_wb_slot;
    t_slot_state        r_wb_state;

    // Output register.
    logic               r_out_valid;
    logic [PAL_W-1:0]   r_out_palette;
    logic [BMP_W-1:0]   r_out_bitmap;
    logic [FLIP_W-1:0]  r_out_flip;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_animated;

    logic               out_free;
    logic               s2_done;
    logic               s2_free;
    logic               s1_move;
    logic               in_accept;
    logic               s2_hit;
    logic               wb_hit;
    logic               s2_load_hit;
    t_slot_state        n_s2_state;
    logic [POS_W-1:0]   cur_pos;
    logic [POS_W-1:0]   nxt_pos;
    logic               nxt_in_range;
    logic               cur_ok;
    logic               nxt_ok;
    logic               cur_byp;
    logic               nxt_byp;
    logic [WORD_W-1:0]  rd_cur;
    logic [WORD_W-1:0]  rd_nxt;
    logic [WORD_W-1:0]  cur_word;
    logic [WORD_W-1:0]  nxt_word;
    t_slot_state        n_slot_state;
    logic               step_animated;
    logic               word_wr_en;

    // Handshake and stage movement.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s2_done    = r_s2_valid && out_free;
    assign s2_free    = !r_s2_valid || out_free;
    assign s1_move    = r_s1_valid && s2_free;
    assign o_in_stall = r_s1_valid && !s2_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Slot state for the first stage: the newest copy wins over the stored one.
    assign s2_hit = r_s2_valid && (r_s2_slot == r_s1_slot);
    assign wb_hit = r_wb_valid && (r_wb_slot == r_s1_slot);

    always_comb begin
        priority if (s2_hit) begin
            n_s2_state = n_slot_state;
        end else if (wb_hit) begin
            n_s2_state = r_wb_state;
        end else if (r_row_valid[r_s1_slot]) begin
            n_s2_state = r_state_rd;
        end else begin
            n_s2_state = '0;
        end
    end

    // Word addresses and written flags; the word after the last reads as empty.
    assign cur_pos      = n_s2_state.pos;
    assign nxt_pos      = cur_pos + POS_W'(1);
    assign nxt_in_range = cur_pos != POS_W'(SEQ_LEN - 1);
    assign cur_ok       = n_s2_state.written[cur_pos];
    assign nxt_ok       = nxt_in_range && n_s2_state.written[nxt_pos];

    // A load in the second stage writes the store at the same edge as this read.
    assign s2_load_hit = s2_hit && (t_cmd'(r_s2_cmd) == CMD_LOAD);
    assign cur_byp     = s2_load_hit && (r_s2_index == cur_pos);
    assign nxt_byp     = s2_load_hit && (r_s2_index == nxt_pos);

    assign word_wr_en = s2_done && (t_cmd'(r_s2_cmd) == CMD_LOAD);

    ias_word_mem u_word_mem (
        .i_clk       (i_clk),
        .i_wr_en     (word_wr_en),
        .i_wr_addr   ({r_s2_slot, r_s2_index}),
        .i_wr_data   (r_s2_word),
        .i_rd_en     (s1_move),
        .i_rd_addr_a ({r_s1_slot, cur_pos}),
        .i_rd_addr_b ({r_s1_slot, nxt_pos}),
        .o_rd_data_a (rd_cur),
        .o_rd_data_b (rd_nxt)
    );

    // Unwritten words read as zero.
    assign cur_word = r_s2_cur_ok ? (r_s2_cur_byp ? r_s2_byp_word : rd_cur) : EMPTY_WORD;
    assign nxt_word = r_s2_nxt_ok ? (r_s2_nxt_byp ? r_s2_byp_word : rd_nxt) : EMPTY_WORD;

    ias_step u_step (
        .i_cmd         (r_s2_cmd),
        .i_entry_index (r_s2_index),
        .i_state       (r_s2_state),
        .i_cur_word    (cur_word),
        .i_nxt_word    (nxt_word),
        .o_state       (n_slot_state),
        .o_animated    (step_animated)
    );

    // Slot state store: read at accept, written when the second stage finishes.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_state_rd <= r_slot_mem[i_icon_slot];
        end
        if (s2_done) begin
            r_slot_mem[r_s2_slot] <= n_slot_state;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_row_valid <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (s2_done) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_done) begin
                r_wb_valid             <= 1'b1;
                r_row_valid[r_s2_slot] <= 1'b1;
                r_out_valid            <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the stages and the output.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd   <= i_cmd;
            r_s1_slot  <= i_icon_slot;
            r_s1_index <= i_entry_index;
            r_s1_word  <= i_entry_word;
        end
        if (s1_move) begin
            r_s2_cmd      <= r_s1_cmd;
            r_s2_slot     <= r_s1_slot;
            r_s2_index    <= r_s1_index;
            r_s2_word     <= r_s1_word;
            r_s2_state    <= n_s2_state;
            r_s2_cur_ok   <= cur_ok;
            r_s2_nxt_ok   <= nxt_ok;
            r_s2_cur_byp  <= cur_byp;
            r_s2_nxt_byp  <= nxt_byp;
            r_s2_byp_word <= r_s2_word;
        end
        if (s2_done) begin
            r_wb_slot      <= r_s2_slot;
            r_wb_state     <= n_slot_state;
            r_out_palette  <= n_slot_state.palette;
            r_out_bitmap   <= n_slot_state.bitmap;
            r_out_flip     <= n_slot_state.flip;
            r_out_pos      <= n_slot_state.pos;
            r_out_animated <= step_animated;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_palette_line   = r_out_palette;
    assign o_bitmap_frame   = r_out_bitmap;
    assign o_flip_mode      = r_out_flip;
    assign o_frame_position = r_out_pos;
    assign o_is_animated    = r_out_animated;

endmodule

// File: hdl/ias_checker.sv
// Port-level checks of the icon animation sequencer, bound to the top level.
// Depends on ias_pkg and the assertion macros in icon_animation_sequencer_unit_assert.svh.
`timescale 1ns / 1ps

`include "icon_animation_sequencer_unit_assert.svh"

module ias_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_stall,
    input  logic [ias_pkg::CMD_W-1:0]   i_cmd,
    input  logic [ias_pkg::SLOT_W-1:0]  i_icon_slot,
    input  logic [ias_pkg::POS_W-1:0]   i_entry_index,
    input  logic [ias_pkg::WORD_W-1:0]  i_entry_word,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic [ias_pkg::PAL_W-1:0]   o_palette_line,
    input  logic [ias_pkg::BMP_W-1:0]   o_bitmap_frame,
    input  logic [ias_pkg::FLIP_W-1:0]  o_flip_mode,
    input  logic [ias_pkg::POS_W-1:0]   o_frame_position,
    input  logic                        o_is_animated
);

    // A stalled result beat stays put.
    `IAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_palette_line) && $stable(o_bitmap_frame) && $stable(o_flip_mode) && $stable(o_frame_position) && $stable(o_is_animated))

    // The block pushes back only when its result register is full and held.
    `IAS_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, !o_out_valid || !i_out_stall, !o_in_stall)

    // Reset empties the pipeline: no result and no back-pressure afterwards.
    `IAS_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind icon_animation_sequencer_unit ias_checker u_ias_checker (.*);
